>>> src/chfp_pkg.sv
// Package for the ClientHello field parser: parse phases, field kinds, error codes, config indices, item types.
// No dependencies.
`default_nettype none
package chfp_pkg;

    typedef enum logic [4:0] {
        PH_VER0, PH_VER1, PH_TIME, PH_RAND, PH_SESS_LEN, PH_SESS,
        PH_SUITES_LEN0, PH_SUITES_LEN1, PH_SUITE0, PH_SUITE1,
        PH_COMP_LEN, PH_COMP, PH_EXTS_LEN0, PH_EXTS_LEN1,
        PH_EXT_T0, PH_EXT_T1, PH_EXT_L0, PH_EXT_L1, PH_EXT_SKIP,
        PH_SNI_L0, PH_SNI_L1, PH_SNI_TYPE, PH_SNI_N0, PH_SNI_N1, PH_SNI_NAME,
        PH_DONE, PH_DEAD
    } phase_t;

    localparam logic [3:0] KIND_VERSION  = 4'd0;
    localparam logic [3:0] KIND_TIME     = 4'd1;
    localparam logic [3:0] KIND_RANDOM   = 4'd2;
    localparam logic [3:0] KIND_SESSION  = 4'd3;
    localparam logic [3:0] KIND_SUITE    = 4'd4;
    localparam logic [3:0] KIND_COMP     = 4'd5;
    localparam logic [3:0] KIND_EXT      = 4'd6;
    localparam logic [3:0] KIND_NAME     = 4'd7;
    localparam logic [3:0] KIND_COMPLETE = 4'd8;
    localparam logic [3:0] KIND_ERROR    = 4'd9;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SESSION   = 3'd1;
    localparam logic [2:0] ERR_ODD       = 3'd2;
    localparam logic [2:0] ERR_TRUNC     = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;
    localparam logic [2:0] ERR_TRAILING  = 3'd5;

    localparam logic CFG_MAX_SESSION = 1'b0;
    localparam logic CFG_PARSE_SNI   = 1'b1;

    localparam logic [15:0] RANDOM_LEN = 16'd28;
    localparam logic [7:0]  DEFAULT_MAX_SESSION = 8'd32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [31:0] field_value;
        logic [15:0] field_position;
        logic [2:0]  error_code;
    } out_item_t;

endpackage
`default_nettype wire

>>> src/chfp_stream_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Depends on nothing.
`default_nettype none
interface chfp_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/client_hello_field_parser_top.sv
// Top level of the ClientHello field parser: byte-serial parse with registered output.
// Depends on chfp_pkg and chfp_stream_if.
//
// Usage:
//   in  : sink channel, one ClientHello body byte per transaction, with
//         end_of_message flagging the final byte.
//   out : source channel, one field transaction per byte at most.
//   cfg : write port; index 0 = max_session_id_len, 1 = parse_server_name.
// Output: a result is registered and appears on out in the cycle after its byte is accepted.
// Throughput: one byte per cycle while out is not stalled; the next parse state is
//   computed combinationally from the phase register, so bytes can follow back to back.
// A single output register holds the result; a byte is accepted whenever
//   that register is empty or being emptied in the same cycle.
// Stall: while out is stalled with a held result, in.ready drops and all
//   parse state holds.
// Reset: parse restarts at the version field, registers take defaults
//   (max session id 32, server name parsing on), the output empties.
// After an error, bytes are dropped silently until end_of_message.
`default_nettype none
module client_hello_field_parser_top
    import chfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    chfp_stream_if.sink   in,
    chfp_stream_if.source out,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0]  max_sess_reg;
    logic        parse_sni_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  comp_reg, comp_next;
    logic [15:0] exts_reg, exts_next;
    logic [15:0] ext_reg, ext_next;
    logic [15:0] list_reg, list_next;
    logic [15:0] etype_reg, etype_next;
    logic        ovalid_reg;
    out_item_t   oitem_reg, res;
    logic        have;
    logic        accept;
    logic [7:0]  b;
    logic [15:0] len;
    phase_t      after_ext_ph;

    assign accept    = in.valid && in.ready;
    assign in.ready  = !ovalid_reg || out.ready;
    assign out.valid = ovalid_reg;
    assign out.payload = oitem_reg;
    assign b   = in.payload.data_byte;
    assign len = {acc_reg[7:0], b};

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        comp_next  = comp_reg;
        exts_next  = exts_reg;
        ext_next   = ext_reg;
        list_next  = list_reg;
        etype_next = etype_reg;
        have = 1'b0;
        res  = '{KIND_VERSION, 32'd0, 16'd0, ERR_NONE};
        after_ext_ph = (exts_reg != 16'd0) ? PH_EXT_T0 : PH_DONE;
        case (phase_reg)
            PH_VER0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_VER1;
            end
            PH_VER1:
            begin
                have = 1'b1; res = '{KIND_VERSION, {16'd0, len}, 16'd0, ERR_NONE};
                acc_next = '0; idx_next = '0; phase_next = PH_TIME;
            end
            PH_TIME:
            begin
                acc_next = {acc_reg[23:0], b};
                idx_next = idx_reg + 16'd1;
                if (idx_reg >= 16'd3)
                begin
                    have = 1'b1; res = '{KIND_TIME, {acc_reg[23:0], b}, 16'd0, ERR_NONE};
                    idx_next = '0; phase_next = PH_RAND;
                end
            end
            PH_RAND:
            begin
                have = 1'b1; res = '{KIND_RANDOM, {24'd0, b}, idx_reg, ERR_NONE};
                idx_next = idx_reg + 16'd1;
                if (idx_reg + 16'd1 >= RANDOM_LEN) phase_next = PH_SESS_LEN;
            end
            PH_SESS_LEN:
            begin
                if (b > max_sess_reg)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_SESSION};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    left_next = {8'd0, b}; idx_next = '0;
                    phase_next = (b != 8'd0) ? PH_SESS : PH_SUITES_LEN0;
                end
            end
            PH_SESS:
            begin
                have = 1'b1; res = '{KIND_SESSION, {24'd0, b}, idx_reg, ERR_NONE};
                idx_next = idx_reg + 16'd1;
                if (left_reg != 16'd0) left_next = left_reg - 16'd1;
                if (left_reg <= 16'd1) phase_next = PH_SUITES_LEN0;
            end
            PH_SUITES_LEN0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_SUITES_LEN1;
            end
            PH_SUITES_LEN1:
            begin
                if (len[0])
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_ODD};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    left_next = len; idx_next = '0;
                    phase_next = (len != 16'd0) ? PH_SUITE0 : PH_COMP_LEN;
                end
            end
            PH_SUITE0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_SUITE1;
            end
            PH_SUITE1:
            begin
                have = 1'b1; res = '{KIND_SUITE, {16'd0, len}, idx_reg, ERR_NONE};
                idx_next = idx_reg + 16'd1;
                left_next = (left_reg >= 16'd2) ? left_reg - 16'd2 : 16'd0;
                phase_next = (left_reg > 16'd2) ? PH_SUITE0 : PH_COMP_LEN;
            end
            PH_COMP_LEN:
            begin
                comp_next = b; idx_next = '0;
                phase_next = (b != 8'd0) ? PH_COMP : PH_EXTS_LEN0;
            end
            PH_COMP:
            begin
                have = 1'b1; res = '{KIND_COMP, {24'd0, b}, idx_reg, ERR_NONE};
                idx_next = idx_reg + 16'd1;
                if (comp_reg != 8'd0) comp_next = comp_reg - 8'd1;
                if (comp_reg <= 8'd1) phase_next = PH_EXTS_LEN0;
            end
            PH_EXTS_LEN0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_EXTS_LEN1;
            end
            PH_EXTS_LEN1:
            begin
                exts_next = len;
                phase_next = (len != 16'd0) ? PH_EXT_T0 : PH_DONE;
            end
            PH_EXT_T0:
            begin
                if (exts_reg < 16'd4)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    exts_next = exts_reg - 16'd4;
                    acc_next = {24'd0, b}; phase_next = PH_EXT_T1;
                end
            end
            PH_EXT_T1:
            begin
                etype_next = len; phase_next = PH_EXT_L0;
            end
            PH_EXT_L0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_EXT_L1;
            end
            PH_EXT_L1:
            begin
                if (len > exts_reg)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    exts_next = exts_reg - len;
                    ext_next = len;
                    have = 1'b1; res = '{KIND_EXT, {16'd0, etype_reg}, len, ERR_NONE};
                    if (len == 16'd0)
                        phase_next = (exts_reg != len) ? PH_EXT_T0 : PH_DONE;
                    else if (etype_reg == 16'd0 && parse_sni_reg)
                        phase_next = PH_SNI_L0;
                    else
                        phase_next = PH_EXT_SKIP;
                end
            end
            PH_EXT_SKIP:
            begin
                if (ext_reg != 16'd0) ext_next = ext_reg - 16'd1;
                if (ext_reg <= 16'd1) phase_next = after_ext_ph;
            end
            PH_SNI_L0:
            begin
                if (ext_reg < 16'd2)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    ext_next = ext_reg - 16'd2;
                    acc_next = {24'd0, b}; phase_next = PH_SNI_L1;
                end
            end
            PH_SNI_L1:
            begin
                if (len > ext_reg)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    ext_next = ext_reg - len;
                    list_next = len;
                    if (len != 16'd0) phase_next = PH_SNI_TYPE;
                    else if (ext_reg != len) phase_next = PH_EXT_SKIP;
                    else phase_next = after_ext_ph;
                end
            end
            PH_SNI_TYPE:
            begin
                if (list_reg < 16'd3)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    list_next = list_reg - 16'd3; phase_next = PH_SNI_N0;
                end
            end
            PH_SNI_N0:
            begin
                acc_next = {24'd0, b}; phase_next = PH_SNI_N1;
            end
            PH_SNI_N1:
            begin
                if (len > list_reg)
                begin
                    have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_OVERRUN};
                    phase_next = PH_DEAD;
                end
                else
                begin
                    list_next = list_reg - len;
                    left_next = len; idx_next = '0;
                    if (len != 16'd0) phase_next = PH_SNI_NAME;
                    else if (list_reg != len) phase_next = PH_SNI_TYPE;
                    else if (ext_reg != 16'd0) phase_next = PH_EXT_SKIP;
                    else phase_next = after_ext_ph;
                end
            end
            PH_SNI_NAME:
            begin
                have = 1'b1; res = '{KIND_NAME, {24'd0, b}, idx_reg, ERR_NONE};
                idx_next = idx_reg + 16'd1;
                if (left_reg != 16'd0) left_next = left_reg - 16'd1;
                if (left_reg <= 16'd1)
                begin
                    if (list_reg != 16'd0) phase_next = PH_SNI_TYPE;
                    else if (ext_reg != 16'd0) phase_next = PH_EXT_SKIP;
                    else phase_next = after_ext_ph;
                end
            end
            PH_DONE:
            begin
                have = 1'b1; res = '{KIND_ERROR, 32'd0, 16'd0, ERR_TRAILING};
                phase_next = PH_DEAD;
            end
            default:
            begin
                phase_next = PH_DEAD;
            end
        endcase

        if (in.payload.end_of_message)
        begin
            if (phase_reg == PH_DEAD)
                have = 1'b0;
            else if (!(have && res.field_kind == KIND_ERROR))
            begin
                have = 1'b1;
                if (phase_next == PH_EXTS_LEN0 || phase_next == PH_DONE)
                    res = '{KIND_COMPLETE, {24'd0, b}, 16'd0, ERR_NONE};
                else
                    res = '{KIND_ERROR, 32'd0, 16'd0, ERR_TRUNC};
            end
            phase_next = PH_VER0;
            left_next = '0; idx_next = '0; acc_next = '0; comp_next = '0;
            exts_next = '0; ext_next = '0; list_next = '0; etype_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sess_reg  <= DEFAULT_MAX_SESSION;
            parse_sni_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SESSION: max_sess_reg  <= cfg_data;
                CFG_PARSE_SNI:   parse_sni_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER0;
            left_reg <= '0; idx_reg <= '0; acc_reg <= '0; comp_reg <= '0;
            exts_reg <= '0; ext_reg <= '0; list_reg <= '0; etype_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                idx_reg   <= idx_next;
                acc_reg   <= acc_next;
                comp_reg  <= comp_next;
                exts_reg  <= exts_next;
                ext_reg   <= ext_next;
                list_reg  <= list_next;
                etype_reg <= etype_next;
                ovalid_reg <= have;
            end
            else if (out.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && have)
            oitem_reg <= res;
    end

endmodule
`default_nettype wire
